/* hw/rtl/cba_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the congestion burst allocator.
// No dependencies.
package cba_pkg;

	localparam int MAX_USERS_DEF = 32;
	localparam int DIV_NW = 40;       // dividend width of the serial divider
	localparam int DIV_DW = 32;       // divisor width of the serial divider
	localparam int IDX_W = 16;
	localparam int UID_W = 8;
	localparam int DFLT_W = 12;
	localparam int BURST_W = 24;
	localparam int CNTO_W = 6;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [IDX_W-1:0] ONE_Q88 = 16'd256;
	localparam logic [IDX_W-1:0] TWO_Q88 = 16'd512;
	localparam logic [IDX_W-1:0] HUNDRED_Q88 = 16'd25600;
	localparam logic [DFLT_W-1:0] DFLT_RST = 12'd256;
	// floor(d/5) == (d*3277) >> 14 for every 12-bit d
	localparam logic [11:0] FIFTH_MUL = 12'd3277;
	localparam int FIFTH_SH = 14;
	localparam logic REG_DEFAULT_BURST = 1'b0;

	typedef enum logic [1:0] {
		DSEL_IDX,
		DSEL_BONUS,
		DSEL_PEN
	} div_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHK,
		ST_DIVI,
		ST_STORE,
		ST_CLOSE,
		ST_SRD,
		ST_SCHK,
		ST_SDIV,
		ST_PEN,
		ST_PDIV,
		ST_ORD,
		ST_OCHK,
		ST_ODIV,
		ST_OEMIT,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic     cap;
		logic     div_start;
		div_sel_t div_sel;
		logic     store;
		logic     rd;
		logic     acc;
		logic     pen_ld;
		logic     emit;
		logic     ptr_clr;
		logic     ptr_inc;
		logic     exc_clr;
		logic     round_clr;
	} cba_cmd_t;

	typedef struct packed {
		logic full;
		logic last;
		logic ptr_end;
		logic cur_cong;
		logic need_pen;
		logic div_done;
	} cba_sts_t;

endpackage

/* hw/rtl/cba_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cba_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 32
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

/* hw/rtl/cba_div.sv */
`timescale 1ns / 1ps
// Restoring serial divider, one quotient bit per cycle.
// Depends on cba_pkg.
module cba_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [cba_pkg::DIV_NW-1:0] dividend,
	input  logic [cba_pkg::DIV_DW-1:0] divisor,
	output logic                      done,
	output logic [cba_pkg::DIV_NW-1:0] quotient
);
	import cba_pkg::*;
	localparam int CW = $clog2(DIV_NW + 1);

	logic [DIV_DW-1:0] rem_q, dvs_q;
	logic [DIV_NW-1:0] quo_q;
	logic [CW-1:0]     cnt_q;
	logic              run_q, done_q;
	logic [DIV_DW:0]   trial;
	logic              ge;

	assign trial = {rem_q, quo_q[DIV_NW-1]};
	assign ge = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(DIV_NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			if (ge) begin
				rem_q <= DIV_DW'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[DIV_DW-1:0];
			end
			quo_q <= {quo_q[DIV_NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
endmodule

/* hw/rtl/cba_ctrl.sv */
`timescale 1ns / 1ps
// Round sequencer: store pass per item, then excess, penalty and output passes.
// Depends on cba_pkg.
module cba_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cba_pkg::cba_sts_t sts,
	output cba_pkg::cba_cmd_t cmd
);
	import cba_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start) state_d = ST_CHK;
			ST_CHK: begin
				if (!sts.full) state_d = ST_DIVI;
				else if (sts.last) state_d = ST_CLOSE;
				else state_d = ST_IDLE;
			end
			ST_DIVI: if (sts.div_done) state_d = ST_STORE;
			ST_STORE: state_d = sts.last ? ST_CLOSE : ST_IDLE;
			ST_CLOSE: state_d = ST_SRD;
			ST_SRD: state_d = sts.ptr_end ? ST_PEN : ST_SCHK;
			ST_SCHK: state_d = sts.cur_cong ? ST_SDIV : ST_SRD;
			ST_SDIV: if (sts.div_done) state_d = ST_SRD;
			ST_PEN: state_d = sts.need_pen ? ST_PDIV : ST_ORD;
			ST_PDIV: if (sts.div_done) state_d = ST_ORD;
			ST_ORD: state_d = sts.ptr_end ? ST_FIN : ST_OCHK;
			ST_OCHK: state_d = sts.cur_cong ? ST_ODIV : ST_OEMIT;
			ST_ODIV: if (sts.div_done) state_d = ST_OEMIT;
			ST_OEMIT: state_d = ST_ORD;
			ST_FIN: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.div_sel = DSEL_IDX;
		unique case (state_q)
			ST_IDLE: cmd.cap = start;
			ST_CHK: cmd.div_start = !sts.full;
			ST_STORE: cmd.store = 1'b1;
			ST_CLOSE: begin
				cmd.ptr_clr = 1'b1;
				cmd.exc_clr = 1'b1;
			end
			ST_SRD: cmd.rd = !sts.ptr_end;
			ST_SCHK: begin
				cmd.div_sel = DSEL_BONUS;
				cmd.div_start = sts.cur_cong;
				cmd.ptr_inc = !sts.cur_cong;
			end
			ST_SDIV: begin
				cmd.acc = sts.div_done;
				cmd.ptr_inc = sts.div_done;
			end
			ST_PEN: begin
				cmd.div_sel = DSEL_PEN;
				cmd.div_start = sts.need_pen;
				cmd.ptr_clr = 1'b1;
			end
			ST_PDIV: cmd.pen_ld = sts.div_done;
			ST_ORD: cmd.rd = !sts.ptr_end;
			ST_OCHK: begin
				cmd.div_sel = DSEL_BONUS;
				cmd.div_start = sts.cur_cong;
			end
			ST_OEMIT: begin
				cmd.emit = 1'b1;
				cmd.ptr_inc = 1'b1;
			end
			ST_FIN: cmd.round_clr = 1'b1;
			default: cmd.round_clr = 1'b0;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	a_start_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !cmd.div_start)
		else $error("divider restarted back to back");
	a_emit_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> $past(state_q) == ST_OCHK || $past(state_q) == ST_ODIV)
		else $error("emit without fresh entry");
	a_cap_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cap |=> busy)
		else $error("item taken but not busy");
endmodule

/* hw/rtl/cba_datapath.sv */
`timescale 1ns / 1ps
// Datapath: input capture, index/bonus/penalty division, user store and result registers.
// Depends on cba_pkg, cba_ram, cba_div.
module cba_datapath #(
	parameter int MAX_USERS = cba_pkg::MAX_USERS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [cba_pkg::UID_W-1:0]     user_id,
	input  logic [31:0]                   queued_bytes,
	input  logic [31:0]                   sent_rate,
	input  logic                          last_user,
	input  logic [cba_pkg::DFLT_W-1:0]    dflt,
	input  cba_pkg::cba_cmd_t             cmd,
	output cba_pkg::cba_sts_t             sts,
	output logic                          strobe,
	output logic [cba_pkg::UID_W-1:0]     out_user_id,
	output logic [cba_pkg::IDX_W-1:0]     congestion_index,
	output logic [cba_pkg::BURST_W-1:0]   burst_credit,
	output logic                          is_congested,
	output logic [cba_pkg::CNTO_W-1:0]    congested_count,
	output logic                          last_result
);
	import cba_pkg::*;
	localparam int CNT_W = $clog2(MAX_USERS + 1);
	localparam int ADDR_W = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
	localparam int EXC_W = 20 + CNT_W;
	localparam int ENT_W = UID_W + IDX_W;

	logic [UID_W-1:0]  uid_q;
	logic [31:0]       queued_q, rate_q;
	logic              last_q;
	logic [CNT_W-1:0]  user_total_q, cong_total_q, ptr_q;
	logic [EXC_W-1:0]  excess_q, pen_q;
	logic              strobe_q;

	logic [DIV_NW-1:0] div_nd, quot;
	logic [DIV_DW-1:0] div_dv;
	logic              div_done;
	logic [ENT_W-1:0]  rd_ent;
	logic [IDX_W-1:0]  idx_new, rd_idx, idx_m;
	logic [27:0]       prod;
	logic [CNT_W-1:0]  normal;
	logic [DFLT_W-1:0] minb, dmm;
	logic [23:0]       fifth_prod;
	logic [BURST_W:0]  cong_sum;
	logic [BURST_W-1:0] burst;
	logic              rd_cong;
	logic [31:0]       nc_ext;

	assign rd_idx = rd_ent[IDX_W-1:0];
	assign rd_cong = rd_idx > ONE_Q88;
	assign idx_m = (rd_idx > TWO_Q88) ? rd_idx : TWO_Q88;
	assign prod = 28'(dflt) * 28'(idx_m);
	assign normal = user_total_q - cong_total_q;

	always_comb begin
		if (rate_q == '0) begin
			idx_new = (queued_q != '0) ? HUNDRED_Q88 : '0;
		end else if (quot > DIV_NW'(16'hFFFF)) begin
			idx_new = 16'hFFFF;
		end else begin
			idx_new = quot[IDX_W-1:0];
		end
	end

	always_comb begin
		unique case (cmd.div_sel)
			DSEL_IDX: begin
				div_nd = {queued_q, 8'd0};
				div_dv = rate_q;
			end
			DSEL_BONUS: begin
				div_nd = DIV_NW'(prod[27:8]);
				div_dv = DIV_DW'(cong_total_q);
			end
			DSEL_PEN: begin
				div_nd = DIV_NW'(excess_q);
				div_dv = DIV_DW'(normal);
			end
			default: begin
				div_nd = '0;
				div_dv = '0;
			end
		endcase
	end

	cba_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_nd),
		.divisor  (div_dv),
		.done     (div_done),
		.quotient (quot)
	);

	cba_ram #(.WIDTH(ENT_W), .DEPTH(MAX_USERS)) u_ram (
		.clk   (clk),
		.we    (cmd.store),
		.waddr (user_total_q[ADDR_W-1:0]),
		.wdata ({uid_q, idx_new}),
		.re    (cmd.rd),
		.raddr (ptr_q[ADDR_W-1:0]),
		.rdata (rd_ent)
	);

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			uid_q <= user_id;
			queued_q <= queued_bytes;
			rate_q <= sent_rate;
			last_q <= last_user;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			user_total_q <= '0;
			cong_total_q <= '0;
			ptr_q <= '0;
			excess_q <= '0;
			pen_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
			if (cmd.store) begin
				user_total_q <= user_total_q + 1'b1;
				if (idx_new > ONE_Q88) cong_total_q <= cong_total_q + 1'b1;
			end else if (cmd.round_clr) begin
				user_total_q <= '0;
				cong_total_q <= '0;
			end
			if (cmd.ptr_clr) ptr_q <= '0;
			else if (cmd.ptr_inc) ptr_q <= ptr_q + 1'b1;
			if (cmd.exc_clr) begin
				excess_q <= '0;
				pen_q <= '0;
			end else begin
				if (cmd.acc) excess_q <= excess_q + EXC_W'(quot[19:0]);
				if (cmd.pen_ld) pen_q <= quot[EXC_W-1:0];
			end
		end
	end

	// minimum credit is a fifth of the default
	assign fifth_prod = 24'(dflt) * 24'(FIFTH_MUL);
	assign minb = DFLT_W'(fifth_prod >> FIFTH_SH);
	assign dmm = dflt - minb;
	assign cong_sum = (BURST_W + 1)'(dflt) + (BURST_W + 1)'(quot[20:0]);

	always_comb begin
		if (rd_cong) begin
			burst = cong_sum[BURST_W] ? '1 : cong_sum[BURST_W-1:0];
		end else if (pen_q > EXC_W'(dmm)) begin
			burst = BURST_W'(minb);
		end else begin
			burst = BURST_W'(dflt - pen_q[DFLT_W-1:0]);
		end
	end

	assign nc_ext = 32'(cong_total_q);

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_user_id <= rd_ent[ENT_W-1:IDX_W];
			congestion_index <= rd_idx;
			burst_credit <= burst;
			is_congested <= rd_cong;
			congested_count <= nc_ext[CNTO_W-1:0];
			last_result <= ((CNT_W + 1)'(ptr_q) + 1'b1) == (CNT_W + 1)'(user_total_q);
		end
	end

	assign strobe = strobe_q;
	assign sts.full = user_total_q >= CNT_W'(MAX_USERS);
	assign sts.last = last_q;
	assign sts.ptr_end = ptr_q >= user_total_q;
	assign sts.cur_cong = rd_cong;
	assign sts.need_pen = (normal != '0) && (excess_q != '0);
	assign sts.div_done = div_done;

	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> ptr_q < user_total_q)
		else $error("emit beyond stored users");
	a_store_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |=> user_total_q == $past(user_total_q) + 1'b1)
		else $error("store did not count");
	a_cong_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		cong_total_q <= user_total_q)
		else $error("congested count above user count");
endmodule

/* hw/rtl/congestion_burst_allocator.sv */
`timescale 1ns / 1ps
// Stored item: check, the 40-step index division, then store; an item
// dropped on a full store takes only the check.
// Closing item then runs the excess pass, a penalty division when needed and the output pass;
// each congested user takes a bonus division in the excess pass and again in the output pass.
// One result beat per user in the output pass; the receiver cannot stall.
// Reset: asynchronous, counts cleared, default_burst back to 1.0; store contents undefined.
module congestion_burst_allocator #(
	parameter int MAX_USERS = cba_pkg::MAX_USERS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [cba_pkg::UID_W-1:0]          user_id,
	input  logic [31:0]                        queued_bytes,
	input  logic [31:0]                        sent_rate,
	input  logic                               last_user,
	output logic                               strobe,
	output logic [cba_pkg::UID_W-1:0]          out_user_id,
	output logic [cba_pkg::IDX_W-1:0]          congestion_index,
	output logic [cba_pkg::BURST_W-1:0]        burst_credit,
	output logic                               is_congested,
	output logic [cba_pkg::CNTO_W-1:0]         congested_count,
	output logic                               last_result,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [cba_pkg::PADDR_W-1:0]        paddr,
	input  logic [cba_pkg::PDATA_W-1:0]        pwdata,
	output logic [cba_pkg::PDATA_W-1:0]        prdata,
	output logic                               pready
);
	import cba_pkg::*;

	logic [DFLT_W-1:0] dflt_q;
	cba_cmd_t cmd;
	cba_sts_t sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_q <= DFLT_RST;
		end else if (psel && penable && pwrite && paddr[2] == REG_DEFAULT_BURST) begin
			dflt_q <= pwdata[DFLT_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_DEFAULT_BURST) ? PDATA_W'(dflt_q) : '0;

	cba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	cba_datapath #(.MAX_USERS(MAX_USERS)) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.user_id          (user_id),
		.queued_bytes     (queued_bytes),
		.sent_rate        (sent_rate),
		.last_user        (last_user),
		.dflt             (dflt_q),
		.cmd              (cmd),
		.sts              (sts),
		.strobe           (strobe),
		.out_user_id      (out_user_id),
		.congestion_index (congestion_index),
		.burst_credit     (burst_credit),
		.is_congested     (is_congested),
		.congested_count  (congested_count),
		.last_result      (last_result)
	);
endmodule
